/* design/cpr_pkg.sv */
// ============================================================================
// cpr_pkg - camera pixel converter shared types
// Pixel format codes and the job record that goes from the byte collector
// to the pixel generator.
// ============================================================================
package cpr_pkg;

  // Input format codes of the mode register
  typedef enum logic [1:0] {
    FMT_RGB444  = 2'd0,
    FMT_RGB555  = 2'd1,
    FMT_RGB565  = 2'd2,
    MODE_YUV422 = 2'd3
  } pixel_mode_t;

  localparam pixel_mode_t MODE_RESET = MODE_YUV422;

  // One complete byte group.
  // RGB: b0 = first byte, b1 = second byte.
  // YUV: b0 = U, b1 = Y0, b2 = V, b3 = Y1.
  typedef struct packed {
    logic        is_yuv;
    pixel_mode_t mode;
    logic [7:0]  b0;
    logic [7:0]  b1;
    logic [7:0]  b2;
    logic [7:0]  b3;
  } job_t;

endpackage

/* design/cpr_front.sv */
// ============================================================================
// cpr_front - byte collector
// Holds the mode register, tracks the byte phase and stores the bytes of
// the current group. Pushes one job per completed group.
// ============================================================================
module cpr_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_wr_data,
  input  logic              accept,
  input  logic [7:0]        data_byte,
  input  logic              frame_start,
  output logic              push,
  output cpr_pkg::job_t     push_job
);

  cpr_pkg::pixel_mode_t mode_r;
  logic [1:0]           phase_r, phase_nxt;
  logic [7:0]           first_r, first_nxt;
  logic [7:0]           second_r, second_nxt;
  logic [7:0]           third_r, third_nxt;
  logic [1:0]           ph;

  // Phase and byte capture
  always_comb begin
    ph         = frame_start ? 2'd0 : phase_r;
    phase_nxt  = phase_r;
    first_nxt  = first_r;
    second_nxt = second_r;
    third_nxt  = third_r;
    push       = 1'b0;
    push_job.is_yuv = (mode_r == cpr_pkg::MODE_YUV422);
    push_job.mode   = mode_r;
    push_job.b0     = first_r;
    push_job.b1     = data_byte;
    push_job.b2     = third_r;
    push_job.b3     = data_byte;
    if (accept) begin
      if (mode_r != cpr_pkg::MODE_YUV422) begin
        // RGB: only the low phase bit counts
        if (!ph[0]) begin
          first_nxt = data_byte;
          phase_nxt = 2'd1;
        end else begin
          phase_nxt = 2'd0;
          push      = 1'b1;
        end
      end else begin
        case (ph)
          2'd0: begin
            first_nxt = data_byte;
            phase_nxt = 2'd1;
          end
          2'd1: begin
            second_nxt = data_byte;
            phase_nxt  = 2'd2;
          end
          2'd2: begin
            third_nxt = data_byte;
            phase_nxt = 2'd3;
          end
          default: begin
            phase_nxt = 2'd0;
            push      = 1'b1;
          end
        endcase
      end
    end
    // Y0 comes from the stored second byte in YUV mode
    if (push_job.is_yuv) begin
      push_job.b1 = second_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= cpr_pkg::MODE_RESET;
      phase_r  <= 2'd0;
      first_r  <= 8'd0;
      second_r <= 8'd0;
      third_r  <= 8'd0;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cpr_pkg::pixel_mode_t'(cfg_wr_data);
      end
      phase_r  <= phase_nxt;
      first_r  <= first_nxt;
      second_r <= second_nxt;
      third_r  <= third_nxt;
    end
  end

endmodule

/* design/cpr_queue.sv */
// ============================================================================
// cpr_queue - job queue
// Small register FIFO between the byte collector and the pixel generator.
// ============================================================================
module cpr_queue #(
  parameter int DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cpr_pkg::job_t push_job,
  input  logic          pop,
  output logic          not_empty,
  output logic          full,
  output cpr_pkg::job_t head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cpr_pkg::job_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign not_empty = (count_r != '0);
  assign full      = (count_r == CNT_W'(DEPTH));
  assign head_job  = mem_r[rd_ptr_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

/* design/cpr_back.sv */
// ============================================================================
// cpr_back - pixel generator
// Turns the head job into one RGB pixel or two YUV pixels and holds each
// in the output register until it is taken.
// ============================================================================
module cpr_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  input  cpr_pkg::job_t job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_red,
  output logic [7:0]    out_green,
  output logic [7:0]    out_blue,
  output logic          out_last_of_run
);

  localparam logic signed [17:0] KV_R = 18'sd360;
  localparam logic signed [17:0] KU_G = 18'sd88;
  localparam logic signed [17:0] KV_G = 18'sd184;
  localparam logic signed [17:0] KU_B = 18'sd455;

  logic              valid_r;
  logic              sub_r;
  logic              load;
  logic signed [7:0] du, dv;
  logic [7:0]        y;
  logic signed [17:0] p_r, p_g, p_b;
  logic [7:0]        red_c, green_c, blue_c;
  logic              last_c;

  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 11'sd255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  // Luma plus floored Q8 term
  function automatic logic [7:0] add_term(input logic [7:0] yv,
                                          input logic signed [17:0] p);
    logic signed [10:0] s;
    s = $signed({3'b000, yv}) + 11'($signed(p[17:8]));
    return clamp8(s);
  endfunction

  assign load = job_valid && (!valid_r || !out_stall);
  assign pop  = load && (!job.is_yuv || sub_r);

  // Pixel from the head job
  always_comb begin
    du  = $signed(job.b0 ^ 8'h80);
    dv  = $signed(job.b2 ^ 8'h80);
    y   = sub_r ? job.b3 : job.b1;
    p_r = 18'(dv) * KV_R;
    p_g = -((18'(du) * KU_G) + (18'(dv) * KV_G));
    p_b = 18'(du) * KU_B;
    last_c = 1'b1;
    if (job.is_yuv) begin
      red_c   = add_term(y, p_r);
      green_c = add_term(y, p_g);
      blue_c  = add_term(y, p_b);
      last_c  = sub_r;
    end else begin
      case (job.mode)
        cpr_pkg::FMT_RGB444: begin
          red_c   = {job.b1[3:0], 4'd0};
          green_c = {job.b1[7:4], 4'd0};
          blue_c  = {job.b0[3:0], 4'd0};
        end
        cpr_pkg::FMT_RGB555: begin
          red_c   = {job.b1[6:2], 3'd0};
          green_c = {job.b1[1:0], job.b0[7:5], 3'd0};
          blue_c  = {job.b0[4:0], 3'd0};
        end
        default: begin
          red_c   = {job.b1[7:3], 3'd0};
          green_c = {job.b1[2:0], job.b0[7:5], 2'd0};
          blue_c  = {job.b0[4:0], 3'd0};
        end
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (load) begin
      out_red         <= red_c;
      out_green       <= green_c;
      out_blue        <= blue_c;
      out_last_of_run <= last_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= 1'b0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        sub_r   <= job.is_yuv && !sub_r;
      end else if (!out_stall) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = valid_r;

endmodule

/* design/camera_pixel_to_rgb888_core.sv */
// ============================================================================
// camera_pixel_to_rgb888_core - camera byte stream to RGB888 pixels
// Pairs RGB444/555/565 bytes into pixels, or converts YUV422 groups into
// two pixels each.
// ============================================================================
//  channel  | ports                                         | direction
//  ---------+-----------------------------------------------+----------
//  input    | in_valid, in_stall, in_data_byte, in_frame_start | in
//  output   | out_valid, out_stall, out_red/green/blue, out_last_of_run | out
//  config   | cfg_wr_en, cfg_wr_data                        | in
//
// One byte accepted per cycle while in_stall is low. A completed group goes
// through the job queue and the output register, the second YUV pixel after
// the first. The output register gives one pixel per cycle while out_stall is
// low; the QUEUE_DEPTH-entry job queue absorbs output stalls, in_stall rises when full.
// Synchronous reset clears phase, queue and output valid; mode resets to YUV422.
module camera_pixel_to_rgb888_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [1:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_data_byte,
  input  logic       in_frame_start,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic       out_last_of_run
);

  logic          accept;
  logic          push;
  logic          pop;
  logic          not_empty;
  logic          full;
  cpr_pkg::job_t push_job;
  cpr_pkg::job_t head_job;

  assign in_stall = full;
  assign accept   = in_valid && !full;

  cpr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .accept      (accept),
    .data_byte   (in_data_byte),
    .frame_start (in_frame_start),
    .push        (push),
    .push_job    (push_job)
  );

  cpr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .not_empty (not_empty),
    .full      (full),
    .head_job  (head_job)
  );

  cpr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .job_valid       (not_empty),
    .job             (head_job),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_of_run (out_last_of_run)
  );

endmodule

/* design/cpr_checker.sv */
// ============================================================================
// cpr_checker - port-level checks for the pixel converter
// Watches the top level ports; attached by bind.
// ============================================================================
module cpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       out_last_of_run
);

  // Reset empties the output register
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // Reset empties the job queue, so input is open again
  a_reset_in: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("in_stall high after reset");

  // The second pixel of a pair follows the first without a gap
  a_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_of_run |=> out_valid)
    else $error("second pixel of pair missing");

  // A stalled pixel holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) &&
    $stable(out_green) && $stable(out_blue) && $stable(out_last_of_run))
    else $error("stalled pixel changed");

endmodule

bind camera_pixel_to_rgb888_core cpr_checker u_cpr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_red         (out_red),
  .out_green       (out_green),
  .out_blue        (out_blue),
  .out_last_of_run (out_last_of_run)
);

/* verif/tb_camera_pixel_to_rgb888_core.sv */
`timescale 1ns / 100ps
// ============================================================================
// tb_camera_pixel_to_rgb888_core - self-checking bench for the pixel converter
// Feeds camera bytes in every input format, with frame starts, broken groups
// and mode changes mid-group. An in-bench predictor works out the expected
// RGB888 pixels, and each pixel leaving the block is checked field by field
// in order. Both sides idle at random, with one stretch where neither does.
// ============================================================================
module tb_camera_pixel_to_rgb888_core;

  // Q8 conversion coefficients
  localparam int KV_R = 360;
  localparam int KU_G = 88;
  localparam int KV_G = 184;
  localparam int KU_B = 455;
  localparam int CHROMA_ZERO = 128;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } rgb_pixel_t;

  // Predicts pixels from accepted bytes and checks the block's output order
  class rgb_pixel_checker;
    cpr_pkg::pixel_mode_t mode;
    logic [1:0]  phase;
    logic [7:0]  byte0;
    logic [7:0]  byte1;
    logic [7:0]  byte2;
    rgb_pixel_t  expected_pixels[$];
    int          errors;

    function new();
      mode   = cpr_pkg::MODE_RESET;
      phase  = 2'd0;
      byte0  = 8'd0;
      byte1  = 8'd0;
      byte2  = 8'd0;
      errors = 0;
    endfunction

    function void set_mode(cpr_pkg::pixel_mode_t m);
      mode = m;
    endfunction

    static function logic [7:0] sat8(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return v[7:0];
    endfunction

    // Arithmetic shift of a signed int floors toward minus infinity
    static function rgb_pixel_t yuv_to_rgb(logic [7:0] y, logic [7:0] u,
                                           logic [7:0] v, logic last);
      int du;
      int dv;
      int luma;
      rgb_pixel_t p;
      du     = int'(u) - CHROMA_ZERO;
      dv     = int'(v) - CHROMA_ZERO;
      luma   = int'(y);
      p.red   = sat8(luma + ((KV_R * dv) >>> 8));
      p.green = sat8(luma + ((-(KU_G * du + KV_G * dv)) >>> 8));
      p.blue  = sat8(luma + ((KU_B * du) >>> 8));
      p.last  = last;
      return p;
    endfunction

    function void note_byte(logic [7:0] d, logic fs);
      rgb_pixel_t p;
      if (fs) phase = 2'd0;
      if (mode != cpr_pkg::MODE_YUV422) begin
        // RGB: only the low phase bit matters
        if (!phase[0]) begin
          byte0 = d;
          phase = 2'd1;
          return;
        end
        phase  = 2'd0;
        p.last = 1'b1;
        case (mode)
          cpr_pkg::FMT_RGB444: begin
            p.red   = {d[3:0], 4'b0};
            p.green = {d[7:4], 4'b0};
            p.blue  = {byte0[3:0], 4'b0};
          end
          cpr_pkg::FMT_RGB555: begin
            p.red   = {d[6:2], 3'b0};
            p.green = {d[1:0], byte0[7:5], 3'b0};
            p.blue  = {byte0[4:0], 3'b0};
          end
          default: begin
            p.red   = {d[7:3], 3'b0};
            p.green = {d[2:0], byte0[7:5], 2'b0};
            p.blue  = {byte0[4:0], 3'b0};
          end
        endcase
        expected_pixels.push_back(p);
        return;
      end
      // YUV422: U, Y0, V, Y1
      case (phase)
        2'd0: begin byte0 = d; phase = 2'd1; end
        2'd1: begin byte1 = d; phase = 2'd2; end
        2'd2: begin byte2 = d; phase = 2'd3; end
        default: begin
          phase = 2'd0;
          expected_pixels.push_back(yuv_to_rgb(byte1, byte0, byte2, 1'b0));
          expected_pixels.push_back(yuv_to_rgb(d, byte0, byte2, 1'b1));
        end
      endcase
    endfunction

    function void check_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic last);
      rgb_pixel_t e;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel: red %0d green %0d blue %0d last %0d",
               r, g, b, last);
        errors++;
        return;
      end
      e = expected_pixels.pop_front();
      if (r !== e.red) begin
        $error("red: expected %0d, got %0d", e.red, r);
        errors++;
      end
      if (g !== e.green) begin
        $error("green: expected %0d, got %0d", e.green, g);
        errors++;
      end
      if (b !== e.blue) begin
        $error("blue: expected %0d, got %0d", e.blue, b);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %0d, got %0d", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  logic [1:0] cfg_wr_data = 2'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_data_byte = 8'd0;
  logic       in_frame_start = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       out_last_of_run;

  logic in_gaps_on = 1'b1;
  logic out_stalls_on = 1'b1;

  rgb_pixel_checker pix_chk = new();

  camera_pixel_to_rgb888_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data_byte    (in_data_byte),
    .in_frame_start  (in_frame_start),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_of_run (out_last_of_run)
  );

  always #4 clk = ~clk;

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall = out_stalls_on && ($urandom_range(99) < 35);
  end

  // Output monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      pix_chk.check_pixel(out_red, out_green, out_blue, out_last_of_run);
  end

  // Run limit
  initial begin
    #2_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Called at a falling edge, returns at a falling edge
  task automatic send_byte(logic [7:0] d, logic fs);
    while (in_gaps_on && $urandom_range(99) < 35) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid       = 1'b1;
    in_data_byte   = d;
    in_frame_start = fs;
    do @(posedge clk); while (in_stall);
    pix_chk.note_byte(d, fs);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic wait_for_pixels();
    while (pix_chk.expected_pixels.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  // Mode writes only once the block has gone quiet
  task automatic set_mode(cpr_pkg::pixel_mode_t m);
    wait_for_pixels();
    repeat (8) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = m;
    pix_chk.set_mode(m);
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  initial begin
    int ph;
    int n;
    int k;
    int len;
    int cut;
    int waited;
    logic resync;
    logic paused;
    logic fs;
    cpr_pkg::pixel_mode_t m;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // YUV422 out of reset: chroma and luma extremes, clamping both ways
    send_byte(8'h00, 1'b1); send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0); send_byte(8'h00, 1'b0);
    // frame start in the middle of a group restarts it
    send_byte(8'h80, 1'b0); send_byte(8'h10, 1'b0);
    send_byte(8'h7F, 1'b1); send_byte(8'hEB, 1'b0);
    send_byte(8'h81, 1'b0); send_byte(8'h80, 1'b0);

    set_mode(cpr_pkg::FMT_RGB444);
    send_byte(8'h0F, 1'b0); send_byte(8'hF0, 1'b0);
    set_mode(cpr_pkg::FMT_RGB555);
    send_byte(8'hE0, 1'b0); send_byte(8'h83, 1'b0);
    send_byte(8'h1F, 1'b0); send_byte(8'h1F, 1'b1); send_byte(8'h7C, 1'b0);
    set_mode(cpr_pkg::FMT_RGB565);
    send_byte(8'h1F, 1'b0); send_byte(8'hF8, 1'b0);
    send_byte(8'hE0, 1'b0); send_byte(8'h07, 1'b0);
    // mode change with a byte held: that byte becomes U
    send_byte(8'hAA, 1'b0);
    set_mode(cpr_pkg::MODE_YUV422);
    send_byte(8'h55, 1'b0); send_byte(8'h33, 1'b0); send_byte(8'h44, 1'b0);

    // Random phases, each under one mode
    for (ph = 0; ph < 10; ph++) begin
      m = (ph < 4) ? cpr_pkg::pixel_mode_t'(ph) :
                     cpr_pkg::pixel_mode_t'($urandom_range(3));
      set_mode(m);
      in_gaps_on    = (ph != 6);
      out_stalls_on = (ph != 6);
      n      = 0;
      resync = 1'b1;
      paused = 1'b0;
      while (n < 82) begin
        len = (m == cpr_pkg::MODE_YUV422) ? 4 : 2;
        cut = ($urandom_range(99) < 6) ? $urandom_range(len - 1, 1) : len;
        for (k = 0; k < cut; k++) begin
          fs = (k == 0 && (resync || $urandom_range(99) < 15)) ||
               ($urandom_range(99) < 3);
          send_byte(8'($urandom_range(255)), fs);
          n++;
        end
        resync = (cut != len);
        // sender holds off until the block has drained
        if (ph == 5 && !paused && n >= 40) begin
          wait_for_pixels();
          paused = 1'b1;
        end
      end
      // sometimes leave a group open across the mode change
      if ($urandom_range(1) == 1) send_byte(8'($urandom_range(255)), 1'b0);
    end

    in_gaps_on = 1'b1;
    waited = 0;
    while (pix_chk.expected_pixels.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (pix_chk.expected_pixels.size() != 0) begin
      $error("%0d expected pixels never arrived", pix_chk.expected_pixels.size());
      pix_chk.errors += pix_chk.expected_pixels.size();
    end
    repeat (20) @(posedge clk);

    if (pix_chk.errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
